### rtl/ipsd_pkg.sv
`default_nettype none
package ipsd_pkg;

   localparam int MAX_ADDRESSES_DEF = 64;
   localparam int OCTET_W           = 8;
   localparam int OCTETS_PER_KEY    = 4;
   localparam int KEY_W             = OCTET_W * OCTETS_PER_KEY;
   localparam int CSR_INDEX_W       = 2;

   localparam logic [OCTET_W-1:0] FIRST_OCTET_RST = 8'd1;
   localparam logic [OCTET_W-1:0] PAIR_FIRST_RST  = 8'd46;
   localparam logic [OCTET_W-1:0] PAIR_SECOND_RST = 8'd70;
   localparam logic [OCTET_W-1:0] ANY_OCTET_RST   = 8'd46;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_OCTET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIR_FIRST  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIR_SECOND = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANY_OCTET   = 2'd3;

   typedef struct packed {
      logic [OCTET_W-1:0] octet_a;
      logic [OCTET_W-1:0] octet_b;
      logic [OCTET_W-1:0] octet_c;
      logic [OCTET_W-1:0] octet_d;
      logic               end_of_set;
   } req_type;

   typedef struct packed {
      logic [OCTET_W-1:0] out_a;
      logic [OCTET_W-1:0] out_b;
      logic [OCTET_W-1:0] out_c;
      logic [OCTET_W-1:0] out_d;
      logic               hit_first;
      logic               hit_pair;
      logic               hit_any;
      logic               dropped;
      logic               final_res;
   } rsp_type;

   typedef struct packed {
      logic [OCTET_W-1:0] first_octet_value;
      logic [OCTET_W-1:0] pair_first_value;
      logic [OCTET_W-1:0] pair_second_value;
      logic [OCTET_W-1:0] any_octet_value;
   } cfg_type;

   typedef struct packed {
      logic hit_first;
      logic hit_pair;
      logic hit_any;
   } hits_type;

   // control broadcast to every cell
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage
`default_nettype wire

### rtl/ipsd_cell.sv
`default_nettype none
module ipsd_cell
   import ipsd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cell_ctl_type     ctl,
   input  wire logic [KEY_W-1:0] new_key,
   input  wire logic             prev_keeps,
   input  wire logic             prev_valid,
   input  wire logic [KEY_W-1:0] prev_key,
   input  wire logic             next_valid,
   input  wire logic [KEY_W-1:0] next_key,
   output logic                  valid,
   output logic [KEY_W-1:0]      key,
   output logic                  keeps
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;

   // entry stays put when it is at least as large as the arriving key
   assign keeps = valid_ff && (key_ff >= new_key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctl.insert && !keeps) begin
         if (prev_keeps) begin
            valid_in = 1'b1;
            key_in   = new_key;
         end else begin
            valid_in = prev_valid;
            key_in   = prev_key;
         end
      end else if (ctl.drain) begin
         valid_in = next_valid;
         key_in   = next_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;

endmodule
`default_nettype wire

### rtl/ipsd_match.sv
`default_nettype none
module ipsd_match
   import ipsd_pkg::*;
(
   input  wire logic [KEY_W-1:0] key,
   input  wire cfg_type          cfg,
   output hits_type              hits
);

   logic [OCTET_W-1:0] a, b, c, d;

   assign a = key[4*OCTET_W-1:3*OCTET_W];
   assign b = key[3*OCTET_W-1:2*OCTET_W];
   assign c = key[2*OCTET_W-1:OCTET_W];
   assign d = key[OCTET_W-1:0];

   assign hits.hit_first = (a == cfg.first_octet_value);
   assign hits.hit_pair  = (a == cfg.pair_first_value) && (b == cfg.pair_second_value);
   assign hits.hit_any   = (a == cfg.any_octet_value) || (b == cfg.any_octet_value) ||
                           (c == cfg.any_octet_value) || (d == cfg.any_octet_value);

endmodule
`default_nettype wire

### rtl/ipv4_sort_descending_with_filters.sv
// the first result word is strobed from the output word register once the control has
// entered the drain state on accepting the word marked end_of_set
// throughput: one address word per cycle while loading; results follow one per cycle
// while busy is high, as the chain shifts head first, and no word is accepted while busy
// reset: synchronous, clears cell valid bits, overflow flag and registers to defaults
// results are strobed for one cycle only; the receiver cannot stall
`default_nettype none
module ipv4_sort_descending_with_filters
   import ipsd_pkg::*;
#(
   parameter int MAX_ADDRESSES = MAX_ADDRESSES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request side
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_data,
   // result side
   output logic                        rsp_valid,
   output rsp_type                     rsp_data,
   // register writes
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [OCTET_W-1:0]     csr_wdata
);

   // chain wiring, one slot per cell
   logic             cell_valid [MAX_ADDRESSES];
   logic [KEY_W-1:0] cell_key   [MAX_ADDRESSES];
   logic             cell_keeps [MAX_ADDRESSES];

   state_type    state_ff, state_in;
   cell_ctl_type ctl;
   logic         accept;
   logic         full;
   logic         overflow_ff, overflow_in;
   logic         last_out;
   cfg_type      cfg_ff, cfg_in;
   hits_type     hits;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;
   logic [KEY_W-1:0] new_key;

   assign accept  = start && !busy;
   assign new_key = {req_data.octet_a, req_data.octet_b, req_data.octet_c, req_data.octet_d};
   // store is full when the tail cell holds a word
   assign full    = cell_valid[MAX_ADDRESSES-1];
   // head word is the last one when its neighbour is empty
   assign last_out = !cell_valid[1];

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_OCTET: cfg_in.first_octet_value = csr_wdata;
            CSR_PAIR_FIRST:  cfg_in.pair_first_value  = csr_wdata;
            CSR_PAIR_SECOND: cfg_in.pair_second_value = csr_wdata;
            CSR_ANY_OCTET:   cfg_in.any_octet_value   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // control: load words into the chain, then shift them out head first
   always_comb begin
      state_in     = state_ff;
      overflow_in  = overflow_ff;
      ctl.insert   = 1'b0;
      ctl.drain    = 1'b0;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  ctl.insert = 1'b1;
               end
               if (req_data.end_of_set) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            ctl.drain    = 1'b1;
            rsp_valid_in = 1'b1;
            if (last_out) begin
               state_in    = ST_IDLE;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff == ST_DRAIN);

   // the chain of cells, cell 0 holds the largest word
   for (genvar i = 0; i < MAX_ADDRESSES; i++) begin : g_cell
      logic             p_keeps, p_valid, n_valid;
      logic [KEY_W-1:0] p_key, n_key;
      if (i == 0) begin : g_head
         assign p_keeps = 1'b1;
         assign p_valid = 1'b0;
         assign p_key   = new_key;
      end else begin : g_body
         assign p_keeps = cell_keeps[i-1];
         assign p_valid = cell_valid[i-1];
         assign p_key   = cell_key[i-1];
      end
      if (i == MAX_ADDRESSES - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_key   = new_key;
      end else begin : g_mid
         assign n_valid = cell_valid[i+1];
         assign n_key   = cell_key[i+1];
      end
      ipsd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_key    (new_key),
         .prev_keeps (p_keeps),
         .prev_valid (p_valid),
         .prev_key   (p_key),
         .next_valid (n_valid),
         .next_key   (n_key),
         .valid      (cell_valid[i]),
         .key        (cell_key[i]),
         .keeps      (cell_keeps[i])
      );
   end

   // match flags on the head word
   ipsd_match u_match (
      .key  (cell_key[0]),
      .cfg  (cfg_ff),
      .hits (hits)
   );

   always_comb begin
      rsp_data_in.out_a     = cell_key[0][4*OCTET_W-1:3*OCTET_W];
      rsp_data_in.out_b     = cell_key[0][3*OCTET_W-1:2*OCTET_W];
      rsp_data_in.out_c     = cell_key[0][2*OCTET_W-1:OCTET_W];
      rsp_data_in.out_d     = cell_key[0][OCTET_W-1:0];
      rsp_data_in.hit_first = hits.hit_first;
      rsp_data_in.hit_pair  = hits.hit_pair;
      rsp_data_in.hit_any   = hits.hit_any;
      rsp_data_in.dropped   = overflow_ff;
      rsp_data_in.final_res = last_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff.first_octet_value <= FIRST_OCTET_RST;
         cfg_ff.pair_first_value  <= PAIR_FIRST_RST;
         cfg_ff.pair_second_value <= PAIR_SECOND_RST;
         cfg_ff.any_octet_value   <= ANY_OCTET_RST;
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      // output word register, payload only
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
